### rtl/layer_priority_blend_compositor_macros.svh
// Assertion macros shared by the compositor RTL.
// Under synthesis every macro expands to nothing.
`ifndef LAYER_PRIORITY_BLEND_COMPOSITOR_MACROS_SVH
`define LAYER_PRIORITY_BLEND_COMPOSITOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off while reset is asserted.
`define LPBC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("compositor check failed");

// Next-cycle implication, held off while reset is asserted.
`define LPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("compositor sequence check failed");

`else

`define LPBC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/lpbc_pkg.sv
package lpbc_pkg;

  // Layer slots: background layers 0-3, then the sprite and the backdrop.
  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_SPRITE   = 3'd4;
  localparam slot_t SLOT_BACKDROP = 3'd5;

  localparam int NUM_LAYERS = 4;
  localparam int NUM_CAND   = NUM_LAYERS + 1;

  localparam logic [11:0] WINDOW_MASKS_RESET = 12'hfff;
  localparam logic [5:0]  MASK_ALL           = 6'h3f;
  localparam logic [4:0]  CHAN_MAX           = 5'd31;
  localparam logic [4:0]  COEF_MAX           = 5'd16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DISPLAY_CONTROL    = 3'd0,
    REG_LAYER_PRIORITIES   = 3'd1,
    REG_WINDOW_HORIZONTAL  = 3'd2,
    REG_WINDOW_VERTICAL    = 3'd3,
    REG_WINDOW_MASKS       = 3'd4,
    REG_BLEND_CONTROL      = 3'd5,
    REG_BLEND_COEFFICIENTS = 3'd6,
    REG_BACKDROP_COLOR     = 3'd7
  } cfg_reg_e;

  // Special effect modes.
  typedef enum logic [1:0] {
    FX_NONE     = 2'd0,
    FX_ALPHA    = 2'd1,
    FX_BRIGHTEN = 2'd2,
    FX_DARKEN   = 2'd3
  } fx_mode_e;

  typedef struct packed {
    logic [15:0] display_control;
    logic [7:0]  layer_priorities;
    logic [15:0] window_horizontal;
    logic [15:0] window_vertical;
    logic [11:0] window_masks;
    logic [13:0] blend_control;
    logic [14:0] blend_coefficients;
    logic [14:0] backdrop_color;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic [7:0]                  pixel_x;
    logic [7:0]                  pixel_y;
    logic [NUM_LAYERS-1:0][14:0] layer_color;
    logic [NUM_LAYERS-1:0]       layer_opaque;
    logic [14:0]                 sprite_color;
    logic                        sprite_opaque;
    logic [1:0]                  sprite_priority;
    logic                        sprite_semi;
  } pixel_t;

  // Layer selection result handed to the effect stage.
  typedef struct packed {
    slot_t top;
    slot_t second;
    logic  top_translucent;
    logic  fx_en;
  } pick_t;

  function automatic logic [4:0] sat16(input logic [4:0] v);
    return (v > COEF_MAX) ? COEF_MAX : v;
  endfunction

  // (a*ca + b*cb) / 16, clipped to the channel maximum.
  function automatic logic [4:0] chan_alpha(input logic [4:0] a, input logic [4:0] b,
                                            input logic [4:0] ca, input logic [4:0] cb);
    logic [9:0]  pa;
    logic [9:0]  pb;
    logic [10:0] sum;
    pa  = a * ca;
    pb  = b * cb;
    sum = {1'b0, pa} + {1'b0, pb};
    return (sum[10:4] > 7'(CHAN_MAX)) ? CHAN_MAX : sum[8:4];
  endfunction

  // a + (31 - a) * cy / 16; never exceeds 31 since cy is at most 16.
  function automatic logic [4:0] chan_brighten(input logic [4:0] a, input logic [4:0] cy);
    logic [9:0] prod;
    logic [5:0] sum;
    prod = (CHAN_MAX - a) * cy;
    sum  = {1'b0, a} + prod[9:4];
    return sum[4:0];
  endfunction

  // a - a * cy / 16; the product term never exceeds a.
  function automatic logic [4:0] chan_darken(input logic [4:0] a, input logic [4:0] cy);
    logic [9:0] prod;
    prod = a * cy;
    return a - prod[8:4];
  endfunction

endpackage

### rtl/lpbc_select.sv
module lpbc_select import lpbc_pkg::*; (
  input  pixel_t pix_i,
  input  cfg_t   cfg_i,
  output pick_t  pick_o
);

  logic       in_window;
  logic [5:0] mask;
  logic [NUM_CAND-1:0] cand;
  logic [4:0] cand_key [NUM_CAND];
  logic [2:0] cand_rank [NUM_CAND];

  // Window test and the enable mask that applies at this pixel.
  always_comb begin
    in_window = (pix_i.pixel_x >= cfg_i.window_horizontal[15:8]) &&
                (pix_i.pixel_x <  cfg_i.window_horizontal[7:0]) &&
                (pix_i.pixel_y >= cfg_i.window_vertical[15:8]) &&
                (pix_i.pixel_y <  cfg_i.window_vertical[7:0]);
    if (cfg_i.display_control[14]) begin
      mask = in_window ? cfg_i.window_masks[5:0] : cfg_i.window_masks[11:6];
    end else begin
      mask = MASK_ALL;
    end
  end

  // Candidates and their sort keys: priority first, then the sprite ahead of
  // background layers, then background layers by index.
  always_comb begin
    for (int i = 0; i < NUM_LAYERS; i++) begin
      cand[i]     = mask[i] & cfg_i.display_control[8+i] & pix_i.layer_opaque[i];
      cand_key[i] = {cfg_i.layer_priorities[2*i +: 2], 3'(i + 1)};
    end
    cand[SLOT_SPRITE]     = pix_i.sprite_opaque & cfg_i.display_control[12] & mask[4];
    cand_key[SLOT_SPRITE] = {pix_i.sprite_priority, 3'd0};
  end

  // Each candidate counts how many live candidates sort ahead of it.
  always_comb begin
    for (int i = 0; i < NUM_CAND; i++) begin
      cand_rank[i] = '0;
      for (int j = 0; j < NUM_CAND; j++) begin
        if (cand[j] && (cand_key[j] < cand_key[i])) begin
          cand_rank[i] = cand_rank[i] + 3'd1;
        end
      end
    end
  end

  // Rank zero is the top layer, rank one the second; the backdrop fills in.
  always_comb begin
    pick_o.top    = SLOT_BACKDROP;
    pick_o.second = SLOT_BACKDROP;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand[i] && (cand_rank[i] == 3'd0)) begin
        pick_o.top = slot_t'(i);
      end
      if (cand[i] && (cand_rank[i] == 3'd1)) begin
        pick_o.second = slot_t'(i);
      end
    end
    pick_o.top_translucent = (pick_o.top == SLOT_SPRITE) && pix_i.sprite_semi;
    pick_o.fx_en           = mask[5];
  end

endmodule

### rtl/lpbc_effect.sv
module lpbc_effect import lpbc_pkg::*; (
  input  pixel_t      pix_i,
  input  cfg_t        cfg_i,
  input  pick_t       pick_i,
  output logic [14:0] color_o
);

  logic [14:0] top_color;
  logic [14:0] second_color;
  logic [5:0]  first_target;
  logic [5:0]  second_target;
  fx_mode_e    mode;
  fx_mode_e    op;
  logic [4:0]  coef_a;
  logic [4:0]  coef_b;
  logic [4:0]  coef_y;

  function automatic logic [14:0] slot_color(input slot_t s, input pixel_t p,
                                              input logic [14:0] backdrop);
    logic [14:0] c;
    case (s)
      3'd0:        c = p.layer_color[0];
      3'd1:        c = p.layer_color[1];
      3'd2:        c = p.layer_color[2];
      3'd3:        c = p.layer_color[3];
      SLOT_SPRITE: c = p.sprite_color;
      default:     c = backdrop;
    endcase
    return c;
  endfunction

  // Colors of the two chosen layers and the decoded controls.
  always_comb begin
    top_color     = slot_color(pick_i.top, pix_i, cfg_i.backdrop_color);
    second_color  = slot_color(pick_i.second, pix_i, cfg_i.backdrop_color);
    first_target  = cfg_i.blend_control[5:0];
    second_target = cfg_i.blend_control[13:8];
    mode          = fx_mode_e'(cfg_i.blend_control[7:6]);
    coef_a        = sat16(cfg_i.blend_coefficients[4:0]);
    coef_b        = sat16(cfg_i.blend_coefficients[9:5]);
    coef_y        = sat16(cfg_i.blend_coefficients[14:10]);
  end

  // Pick the effect. A semi-transparent sprite on top blends whatever the
  // mode; the backdrop on top is never alpha-blended.
  always_comb begin
    op = FX_NONE;
    if (pick_i.fx_en && pick_i.top_translucent && second_target[pick_i.second]) begin
      op = FX_ALPHA;
    end else if (pick_i.fx_en && first_target[pick_i.top]) begin
      case (mode)
        FX_ALPHA: begin
          if ((pick_i.top != SLOT_BACKDROP) && second_target[pick_i.second]) begin
            op = FX_ALPHA;
          end
        end
        FX_BRIGHTEN: op = FX_BRIGHTEN;
        FX_DARKEN:   op = FX_DARKEN;
        default:     op = FX_NONE;
      endcase
    end
  end

  // Per-channel arithmetic.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      case (op)
        FX_ALPHA: begin
          color_o[5*ch +: 5] = chan_alpha(top_color[5*ch +: 5], second_color[5*ch +: 5],
                                          coef_a, coef_b);
        end
        FX_BRIGHTEN: color_o[5*ch +: 5] = chan_brighten(top_color[5*ch +: 5], coef_y);
        FX_DARKEN:   color_o[5*ch +: 5] = chan_darken(top_color[5*ch +: 5], coef_y);
        default:     color_o[5*ch +: 5] = top_color[5*ch +: 5];
      endcase
    end
  end

endmodule

### rtl/layer_priority_blend_compositor.sv
// Pipeline: an accepted beat is held in the input register and moves into the output
// register when that register is empty or its beat is being taken.
// Throughput: one pixel per cycle while out_stall_i is low; the input register feeds
// the output register through one pass of window, layer selection and blend logic.
// Reset: asynchronous, active low; clears both valid flags and sets every
// configuration register to zero except window_masks, which resets to all ones.
`include "layer_priority_blend_compositor_macros.svh"

module layer_priority_blend_compositor import lpbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [14:0] layer0_color_i,
  input  logic [14:0] layer1_color_i,
  input  logic [14:0] layer2_color_i,
  input  logic [14:0] layer3_color_i,
  input  logic [3:0]  layer_opaque_i,
  input  logic [14:0] sprite_color_i,
  input  logic        sprite_opaque_i,
  input  logic [1:0]  sprite_priority_i,
  input  logic        sprite_semi_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] pixel_color_o
);

  cfg_t        cfg_q;
  pixel_t      pix_q;
  pixel_t      pix_d;
  logic        pix_valid_q;
  logic        pix_valid_d;
  logic        out_valid_q;
  logic        out_valid_d;
  logic [14:0] pixel_color_q;
  logic [14:0] pixel_color_d;
  logic        out_free;
  logic        pix_fire;
  logic        in_fire;
  pick_t       pick;
  logic [14:0] blend_color;
  logic        pick_distinct;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.window_masks <= WINDOW_MASKS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DISPLAY_CONTROL:    cfg_q.display_control    <= cfg_data_i;
        REG_LAYER_PRIORITIES:   cfg_q.layer_priorities   <= cfg_data_i[7:0];
        REG_WINDOW_HORIZONTAL:  cfg_q.window_horizontal  <= cfg_data_i;
        REG_WINDOW_VERTICAL:    cfg_q.window_vertical    <= cfg_data_i;
        REG_WINDOW_MASKS:       cfg_q.window_masks       <= cfg_data_i[11:0];
        REG_BLEND_CONTROL:      cfg_q.blend_control      <= cfg_data_i[13:0];
        REG_BLEND_COEFFICIENTS: cfg_q.blend_coefficients <= cfg_data_i[14:0];
        REG_BACKDROP_COLOR:     cfg_q.backdrop_color     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the output register is
  // empty or its beat is being taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pix_fire   = pix_valid_q && out_free;
  assign in_stall_o = pix_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign pix_valid_d = in_fire || (pix_valid_q && !pix_fire);
  assign out_valid_d = pix_fire || (out_valid_q && out_stall_i);

  // Gather the input beat.
  always_comb begin
    pix_d                 = pix_q;
    if (in_fire) begin
      pix_d.pixel_x         = pixel_x_i;
      pix_d.pixel_y         = pixel_y_i;
      pix_d.layer_color[0]  = layer0_color_i;
      pix_d.layer_color[1]  = layer1_color_i;
      pix_d.layer_color[2]  = layer2_color_i;
      pix_d.layer_color[3]  = layer3_color_i;
      pix_d.layer_opaque    = layer_opaque_i;
      pix_d.sprite_color    = sprite_color_i;
      pix_d.sprite_opaque   = sprite_opaque_i;
      pix_d.sprite_priority = sprite_priority_i;
      pix_d.sprite_semi     = sprite_semi_i;
    end
  end

  assign pixel_color_d = pix_fire ? blend_color : pixel_color_q;

  // Pipeline control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pix_q         <= pix_d;
    pixel_color_q <= pixel_color_d;
  end

  // Window, layer selection and special effects.
  lpbc_select u_select (
    .pix_i  (pix_q),
    .cfg_i  (cfg_q),
    .pick_o (pick)
  );

  lpbc_effect u_effect (
    .pix_i   (pix_q),
    .cfg_i   (cfg_q),
    .pick_i  (pick),
    .color_o (blend_color)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = pixel_color_q;

  // The top and second layers are never the same layer, unless both are the backdrop.
  assign pick_distinct = (pick.top != pick.second) || (pick.top == SLOT_BACKDROP);

  // Checks on the pipeline and the layer selection.
  `LPBC_ASSERT_IMPLIES(a_stall_needs_item, clk_i, rst_ni, in_stall_o, pix_valid_q)
  `LPBC_ASSERT_NEXT(a_accept_fills_input, clk_i, rst_ni, in_fire, pix_valid_q)
  `LPBC_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni, pix_fire, out_valid_o)
  `LPBC_ASSERT_IMPLIES(a_top_second_differ, clk_i, rst_ni, pix_valid_q, pick_distinct)

endmodule

### tb/compositor_pixel_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both pixel channels. It keeps its own copy
// of the settings and works out the color that every accepted input beat must
// produce. Each output beat is then compared in order with those expected colors.
module compositor_pixel_checker import lpbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  pixel_t      pixel_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [14:0] pixel_color_i,
  output int          mismatch_count_o,
  output int          colors_pending_o
);

  // Bit positions inside the display control, the window mask and the blend control.
  localparam int DC_LAYER_LSB   = 8;
  localparam int DC_SPRITE      = 12;
  localparam int DC_WINDOW      = 14;
  localparam int MASK_SPRITE    = 4;
  localparam int MASK_EFFECTS   = 5;
  localparam int SECOND_TGT_LSB = 8;
  // Blend weights are in sixteenths.
  localparam int unsigned BLEND_ONE = 16;

  cfg_t        settings;
  logic [14:0] expected_colors[$];
  logic [14:0] want_color;

  // Limits a five-bit coefficient to one whole.
  function automatic int unsigned coef_limit(input logic [4:0] raw);
    return (raw > COEF_MAX) ? COEF_MAX : raw;
  endfunction

  // Applies one effect to the three channels of a color.
  function automatic logic [14:0] mix_channels(input logic [14:0] upper,
                                               input logic [14:0] lower,
                                               input fx_mode_e fx,
                                               input int unsigned ka,
                                               input int unsigned kb,
                                               input int unsigned ky);
    logic [14:0] mixed;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    for (int ch = 0; ch < 3; ch++) begin
      a = upper[ch*5 +: 5];
      b = lower[ch*5 +: 5];
      case (fx)
        FX_ALPHA: begin
          c = (a * ka + b * kb) / BLEND_ONE;
          if (c > CHAN_MAX) c = CHAN_MAX;
        end
        FX_BRIGHTEN: c = a + ((CHAN_MAX - a) * ky) / BLEND_ONE;
        FX_DARKEN:   c = a - (a * ky) / BLEND_ONE;
        default:     c = a;
      endcase
      mixed[ch*5 +: 5] = c[4:0];
    end
    return mixed;
  endfunction

  // Works out the final color of one pixel under the current settings.
  function automatic logic [14:0] compose_pixel(input pixel_t px);
    logic [5:0]  mask;
    logic        in_window;
    logic        sprite_on;
    slot_t       top;
    slot_t       second;
    logic        top_translucent;
    logic [14:0] palette [6];
    fx_mode_e    fx;
    int unsigned ka;
    int unsigned kb;
    int unsigned ky;
    logic [14:0] color;

    // Window: pick the inside or outside mask, or enable everything.
    mask = MASK_ALL;
    if (settings.display_control[DC_WINDOW]) begin
      in_window = px.pixel_x >= settings.window_horizontal[15:8] &&
                  px.pixel_x <  settings.window_horizontal[7:0] &&
                  px.pixel_y >= settings.window_vertical[15:8] &&
                  px.pixel_y <  settings.window_vertical[7:0];
      mask = in_window ? settings.window_masks[5:0] : settings.window_masks[11:6];
    end
    sprite_on = px.sprite_opaque && settings.display_control[DC_SPRITE] &&
                mask[MASK_SPRITE];

    for (int l = 0; l < NUM_LAYERS; l++) palette[l] = px.layer_color[l];
    palette[SLOT_SPRITE]   = px.sprite_color;
    palette[SLOT_BACKDROP] = settings.backdrop_color;

    // Priority scan: the sprite goes ahead of backgrounds at equal priority.
    top             = SLOT_BACKDROP;
    second          = SLOT_BACKDROP;
    top_translucent = 1'b0;
    for (int pri = 0; pri < 4; pri++) begin
      if (sprite_on && px.sprite_priority == pri) begin
        if (top == SLOT_BACKDROP) begin
          top             = SLOT_SPRITE;
          top_translucent = px.sprite_semi;
        end else if (second == SLOT_BACKDROP) begin
          second = SLOT_SPRITE;
        end
      end
      for (int l = 0; l < NUM_LAYERS; l++) begin
        if (mask[l] && settings.display_control[DC_LAYER_LSB + l] &&
            settings.layer_priorities[2*l +: 2] == pri && px.layer_opaque[l]) begin
          if (top == SLOT_BACKDROP) top = slot_t'(l);
          else if (second == SLOT_BACKDROP) second = slot_t'(l);
        end
      end
      if (second != SLOT_BACKDROP) break;
    end

    // Special effects.
    fx    = fx_mode_e'(settings.blend_control[7:6]);
    ka    = coef_limit(settings.blend_coefficients[4:0]);
    kb    = coef_limit(settings.blend_coefficients[9:5]);
    ky    = coef_limit(settings.blend_coefficients[14:10]);
    color = palette[top];
    if (mask[MASK_EFFECTS] && top_translucent &&
        settings.blend_control[SECOND_TGT_LSB + second]) begin
      // A semi-transparent sprite on top blends whatever the mode.
      color = mix_channels(palette[top], palette[second], FX_ALPHA, ka, kb, ky);
    end else if (mask[MASK_EFFECTS] && settings.blend_control[top]) begin
      if (fx == FX_ALPHA && top != SLOT_BACKDROP &&
          settings.blend_control[SECOND_TGT_LSB + second])
        color = mix_channels(palette[top], palette[second], FX_ALPHA, ka, kb, ky);
      else if (fx == FX_BRIGHTEN || fx == FX_DARKEN)
        color = mix_channels(palette[top], '0, fx, ka, kb, ky);
    end
    return color;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count_o++;
  endtask

  // Settings copy, expected colors and comparison of every output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings              = '0;
      settings.window_masks = WINDOW_MASKS_RESET;
      expected_colors.delete();
      mismatch_count_o      = 0;
      colors_pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DISPLAY_CONTROL:    settings.display_control    = cfg_data_i;
          REG_LAYER_PRIORITIES:   settings.layer_priorities   = cfg_data_i[7:0];
          REG_WINDOW_HORIZONTAL:  settings.window_horizontal  = cfg_data_i;
          REG_WINDOW_VERTICAL:    settings.window_vertical    = cfg_data_i;
          REG_WINDOW_MASKS:       settings.window_masks       = cfg_data_i[11:0];
          REG_BLEND_CONTROL:      settings.blend_control      = cfg_data_i[13:0];
          REG_BLEND_COEFFICIENTS: settings.blend_coefficients = cfg_data_i[14:0];
          REG_BACKDROP_COLOR:     settings.backdrop_color     = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_colors.push_back(compose_pixel(pixel_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("output beat %h with no pixel waiting", pixel_color_i));
        end else begin
          want_color = expected_colors.pop_front();
          if (pixel_color_i !== want_color)
            report_mismatch($sformatf("pixel_color is %h, expected %h",
                                      pixel_color_i, want_color));
        end
      end
      colors_pending_o = expected_colors.size();
    end
  end

endmodule

### tb/layer_priority_blend_compositor_tb.sv
`timescale 1ns / 100ps

module layer_priority_blend_compositor_tb import lpbc_pkg::*; ();

  // Cycles allowed after the last expected color has been taken.
  localparam int DRAIN_CYCLES = 4;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  pixel_t      pixel_q     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [14:0] pixel_color;
  int          mismatch_count;
  int          colors_pending;
  bit          calm        = 1'b0;

  always #6 clk = ~clk;

  layer_priority_blend_compositor u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pixel_x_i         (pixel_q.pixel_x),
    .pixel_y_i         (pixel_q.pixel_y),
    .layer0_color_i    (pixel_q.layer_color[0]),
    .layer1_color_i    (pixel_q.layer_color[1]),
    .layer2_color_i    (pixel_q.layer_color[2]),
    .layer3_color_i    (pixel_q.layer_color[3]),
    .layer_opaque_i    (pixel_q.layer_opaque),
    .sprite_color_i    (pixel_q.sprite_color),
    .sprite_opaque_i   (pixel_q.sprite_opaque),
    .sprite_priority_i (pixel_q.sprite_priority),
    .sprite_semi_i     (pixel_q.sprite_semi),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .pixel_color_o     (pixel_color)
  );

  compositor_pixel_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pixel_i          (pixel_q),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_color_i    (pixel_color),
    .mismatch_count_o (mismatch_count),
    .colors_pending_o (colors_pending)
  );

  // Colors lean toward black and white so that channel saturation is hit often.
  function automatic logic [14:0] random_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 15'($urandom);
    endcase
  endfunction

  // Mostly on-screen coordinates, with some beyond the visible area.
  function automatic pixel_t random_pixel();
    pixel_t p;
    p.pixel_x = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(240, 255))
                                             : 8'($urandom_range(0, 239));
    p.pixel_y = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(160, 255))
                                             : 8'($urandom_range(0, 159));
    for (int l = 0; l < NUM_LAYERS; l++) p.layer_color[l] = random_color();
    p.layer_opaque    = 4'($urandom);
    p.sprite_color    = random_color();
    p.sprite_opaque   = 1'($urandom);
    p.sprite_priority = 2'($urandom);
    p.sprite_semi     = 1'($urandom);
    return p;
  endfunction

  // Random settings; windows are usually well-formed, sometimes arbitrary.
  function automatic cfg_t random_settings();
    cfg_t       c;
    logic [7:0] near_edge;
    c.display_control = 16'($urandom);
    if ($urandom_range(0, 1)) c.display_control[12:8] = 5'h1f;
    c.layer_priorities = 8'($urandom);
    near_edge = 8'($urandom_range(0, 200));
    if ($urandom_range(0, 3) == 0) c.window_horizontal = 16'($urandom);
    else c.window_horizontal = {near_edge, 8'(near_edge + $urandom_range(1, 55))};
    near_edge = 8'($urandom_range(0, 140));
    if ($urandom_range(0, 3) == 0) c.window_vertical = 16'($urandom);
    else c.window_vertical = {near_edge, 8'(near_edge + $urandom_range(1, 60))};
    c.window_masks       = 12'($urandom);
    c.blend_control      = 14'($urandom);
    c.blend_coefficients = 15'($urandom);
    c.backdrop_color     = random_color();
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Writes every register; unused upper data bits carry random filler.
  task automatic load_settings(input cfg_t c);
    logic [15:0] filler;
    filler = 16'($urandom);
    write_reg(REG_DISPLAY_CONTROL, c.display_control);
    write_reg(REG_LAYER_PRIORITIES, {filler[15:8], c.layer_priorities});
    write_reg(REG_WINDOW_HORIZONTAL, c.window_horizontal);
    write_reg(REG_WINDOW_VERTICAL, c.window_vertical);
    write_reg(REG_WINDOW_MASKS, {filler[15:12], c.window_masks});
    write_reg(REG_BLEND_CONTROL, {filler[15:14], c.blend_control});
    write_reg(REG_BLEND_COEFFICIENTS, {filler[15], c.blend_coefficients});
    write_reg(REG_BACKDROP_COLOR, {filler[14], c.backdrop_color});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one input beat, sometimes after an idle burst, and holds it until taken.
  task automatic send_pixel(input pixel_t p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    pixel_q  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every expected color has come out, then a few cycles more.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Output stalls come in bursts until the final calm stretch.
  initial begin : output_stalls
    @(posedge rst_n);
    while (!calm) begin
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("layer_priority_blend_compositor: mismatch");
    $finish;
  end

  initial begin : stimulus
    pixel_t p;
    cfg_t   c;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: nothing enabled, so the black backdrop shows.
    repeat (2) send_pixel(random_pixel());
    drain();

    // Alpha blend with saturated coefficients; inside is 16 <= x < 128, 16 <= y < 96,
    // and the outside mask drops the sprite.
    c = '0;
    c.display_control    = 16'h5f00;
    c.layer_priorities   = 8'he4;
    c.window_horizontal  = {8'd16, 8'd128};
    c.window_vertical    = {8'd16, 8'd96};
    c.window_masks       = {6'h2f, 6'h3f};
    c.blend_control      = {6'h3f, FX_ALPHA, 6'h3f};
    c.blend_coefficients = '1;
    c.backdrop_color     = '1;
    load_settings(c);
    p = random_pixel();
    p.pixel_x = 8'd0;   p.pixel_y = 8'd0;
    p.layer_opaque = '1; p.layer_color = '1;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd239; p.pixel_y = 8'd159;
    p.layer_opaque = '0; p.sprite_opaque = 1'b1;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd255; p.pixel_y = 8'd255;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd16;  p.pixel_y = 8'd16;
    p.layer_opaque = '0; p.sprite_opaque = 1'b1; p.sprite_priority = 2'd0;
    p.sprite_semi = 1'b1;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd127; p.pixel_y = 8'd95;
    p.layer_opaque = '1; p.layer_color = '0; p.sprite_opaque = 1'b1;
    p.sprite_priority = 2'd3; p.sprite_semi = 1'b0;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd100; p.pixel_y = 8'd50;
    p.layer_opaque = 4'b1000; p.sprite_opaque = 1'b1; p.sprite_priority = 2'd3;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd128; p.pixel_y = 8'd95;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd16;  p.pixel_y = 8'd96;
    send_pixel(p);
    p = random_pixel();
    p.pixel_x = 8'd50;  p.pixel_y = 8'd50;
    p.layer_opaque = 4'b0011; p.sprite_opaque = 1'b1; p.sprite_priority = 2'd2;
    p.sprite_semi = 1'b1;
    send_pixel(p);
    drain();

    // Brighten with the window off and an over-range brightness.
    c = '0;
    c.display_control    = 16'h1f00;
    c.window_masks       = '0;
    c.blend_control      = {6'h00, FX_BRIGHTEN, 6'h3f};
    c.blend_coefficients = {5'd20, 5'd0, 5'd0};
    c.backdrop_color     = 15'h1234;
    load_settings(c);
    p = random_pixel();
    p.layer_opaque = '0; p.sprite_opaque = 1'b0;
    send_pixel(p);
    p = random_pixel();
    p.layer_opaque = '1; p.layer_color = '0;
    send_pixel(p);
    send_pixel(random_pixel());
    drain();

    // Darken under an inverted window, so every pixel takes the outside mask.
    c = '0;
    c.display_control    = 16'h5f00;
    c.layer_priorities   = 8'h1b;
    c.window_horizontal  = {8'd200, 8'd10};
    c.window_vertical    = {8'd0, 8'd255};
    c.window_masks       = {6'h3f, 6'h00};
    c.blend_control      = {6'h1f, FX_DARKEN, 6'h3f};
    c.blend_coefficients = {5'd8, 5'd12, 5'd4};
    c.backdrop_color     = 15'h7c1f;
    load_settings(c);
    p = random_pixel();
    p.layer_opaque = '1; p.sprite_opaque = 1'b1; p.sprite_priority = 2'd0;
    p.sprite_semi = 1'b1;
    send_pixel(p);
    p = random_pixel();
    p.layer_opaque = '0; p.sprite_opaque = 1'b1; p.sprite_semi = 1'b1;
    send_pixel(p);
    p = random_pixel();
    p.sprite_semi = 1'b0;
    send_pixel(p);
    drain();

    // Random settings, each followed by a run of random pixels.
    for (int phase = 0; phase < 8; phase++) begin
      load_settings(random_settings());
      repeat (64) send_pixel(random_pixel());
      drain();
    end

    // Closing stretch without idling on either side: all-zero and all-one settings.
    calm = 1'b1;
    load_settings('0);
    repeat (40) send_pixel(random_pixel());
    drain();
    load_settings('1);
    repeat (40) send_pixel(random_pixel());
    drain();

    if (mismatch_count == 0) begin
      $display("layer_priority_blend_compositor: match");
    end else begin
      $display("layer_priority_blend_compositor: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lpbc_pkg.sv
rtl/lpbc_select.sv
rtl/lpbc_effect.sv
rtl/layer_priority_blend_compositor.sv
tb/compositor_pixel_checker.sv
tb/layer_priority_blend_compositor_tb.sv
